[rtl/core/tsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared constants for the scanline triangle rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;
    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int COLOR_BITS     = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_AX    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AY    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BX    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BY    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CX    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CY    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLOR = 3'd6;
endpackage
`default_nettype wire

[rtl/core/tsr_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_divider
// Restoring divider, one quotient bit per cycle, floor semantics for a
// signed numerator over a positive divisor.
// ----------------------------------------------------------------------------
module tsr_divider #(
    parameter int NB = 26,
    parameter int DB = 12
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire signed [NB-1:0] i_num,
    input  wire [DB-1:0]     i_den,
    output logic             o_done,
    output logic signed [NB-1:0] o_quo
);
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] r_q, n_q;
    logic [DB:0]   r_rem, n_rem;
    logic [DB-1:0] r_den;
    logic          r_neg, r_busy, n_busy, r_done;
    logic [CB-1:0] r_cnt, n_cnt;
    logic [NB-1:0] mag;
    logic [DB+1:0] trial;
    logic [NB-1:0] qpos;
    logic [NB-1:0] qneg;

    assign mag = i_num[NB-1] ? NB'(-i_num) : NB'(i_num);

    always_comb begin
        trial  = {r_rem, r_q[NB-1]} - {2'b00, r_den};
        n_q    = {r_q[NB-2:0], 1'b0};
        n_rem  = {r_rem[DB-1:0], r_q[NB-1]};
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (r_busy) begin
            if (!trial[DB+1]) begin
                n_rem = trial[DB:0];
                n_q[0] = 1'b1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CB'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !n_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(NB);
                r_q    <= mag;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[NB-1];
            end else if (r_busy) begin
                r_busy <= n_busy;
                r_cnt  <= n_cnt;
                r_q    <= n_q;
                r_rem  <= n_rem;
            end
        end
    end

    // round toward minus infinity for a negative numerator
    assign qpos = r_q;
    assign qneg = (r_rem != '0) ? NB'(~r_q) : NB'(-r_q);
    assign o_quo  = r_neg ? signed'(qneg) : signed'(qpos);
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/core/triangle_scanline_rasterizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_scanline_rasterizer
// Scanline triangle fill, one pixel word per advance item.
// ----------------------------------------------------------------------------
// A start word latches and sorts the configured vertices; an advance word emits
// the next covered pixel. Along a span one pixel word is accepted and handed off
// per cycle while the output is not stalled. At each row change the block
// computes both edge points with a shared serial divider, and o_stall stays high
// while it does so. A start sorts in its accept cycle and then runs one row
// setup, or returns to idle when all three vertices share a row.
// ----------------------------------------------------------------------------
module triangle_scanline_rasterizer
    import tsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [tsr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [tsr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_start_req,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [COORD_BITS-1:0]       o_pixel_x,
    output logic [COORD_BITS-1:0]       o_pixel_y,
    output logic [tsr_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                        o_last_pixel
);
    localparam int CB = COORD_BITS;
    localparam int NB = 2 * CB + 2;
    localparam logic [2:0] S_IDLE = 3'd0, S_DRAW = 3'd1, S_DIVA = 3'd2,
                           S_DIVB = 3'd3, S_SPAN = 3'd4;

    logic [CB-1:0] r_vx [3];
    logic [CB-1:0] r_vy [3];
    logic [COLOR_BITS-1:0] r_color;
    logic [CB-1:0] r_sx [3];
    logic [CB-1:0] r_sy [3];
    logic [CB-1:0] r_row, r_col, r_end;
    logic [2:0]    r_st;
    logic signed [CB+1:0] r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
            r_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AX:    r_vx[0] <= i_cfg_data[CB-1:0];
                REG_AY:    r_vy[0] <= i_cfg_data[CB-1:0];
                REG_BX:    r_vx[1] <= i_cfg_data[CB-1:0];
                REG_BY:    r_vy[1] <= i_cfg_data[CB-1:0];
                REG_CX:    r_vx[2] <= i_cfg_data[CB-1:0];
                REG_CY:    r_vy[2] <= i_cfg_data[CB-1:0];
                REG_COLOR: r_color <= i_cfg_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // three compare-and-swap steps on the configured vertices
    logic [CB-1:0] x0, x1, x2, y0, y1, y2, tx, ty;
    always_comb begin
        tx = '0; ty = '0;
        x0 = r_vx[0]; x1 = r_vx[1]; x2 = r_vx[2];
        y0 = r_vy[0]; y1 = r_vy[1]; y2 = r_vy[2];
        if (y0 > y1) begin tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty; end
        if (y0 > y2) begin tx = x0; ty = y0; x0 = x2; y0 = y2; x2 = tx; y2 = ty; end
        if (y1 > y2) begin tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty; end
    end

    // divider operand selection
    logic [CB-1:0] tot, h1, h2;
    logic          second;
    logic signed [CB+1:0] dx_l, dx_s;
    logic [CB-1:0] i_eff;
    logic signed [NB-1:0] num;
    logic [CB-1:0] den;
    logic          dv_start, dv_done;
    logic signed [NB-1:0] quo;
    logic signed [CB+1:0] b_val, lo, hi;

    assign tot    = r_sy[2] - r_sy[0];
    assign h1     = r_sy[1] - r_sy[0];
    assign h2     = r_sy[2] - r_sy[1];
    assign second = (r_row > h1) || (h1 == '0);
    assign dx_l   = $signed({2'b00, r_sx[2]}) - $signed({2'b00, r_sx[0]});
    assign dx_s   = second ? $signed({2'b00, r_sx[2]}) - $signed({2'b00, r_sx[1]})
                           : $signed({2'b00, r_sx[1]}) - $signed({2'b00, r_sx[0]});
    assign i_eff  = second ? r_row - h1 : r_row;

    always_comb begin
        if (r_st == S_DIVA) begin
            num = NB'(dx_l * $signed({2'b00, r_row}));
            den = tot;
        end else begin
            num = NB'(dx_s * $signed({2'b00, i_eff}));
            den = second ? h2 : h1;
        end
    end

    logic r_kick;
    assign dv_start = r_kick;

    tsr_divider #(.NB(NB), .DB(CB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(num), .i_den(den), .o_done(dv_done), .o_quo(quo)
    );

    assign b_val = (second ? $signed({2'b00, r_sx[1]}) : $signed({2'b00, r_sx[0]}))
                   + $signed(quo[CB+1:0]);
    assign lo = (r_a < b_val) ? r_a : b_val;
    assign hi = (r_a < b_val) ? b_val : r_a;

    logic take_in, out_free, is_last, emit, n_kick;
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = !((r_st == S_IDLE || r_st == S_DRAW) && out_free);
    assign take_in  = i_valid && !o_stall;
    assign is_last  = (r_col == r_end) && (r_row + 1'b1 == tot);
    assign emit     = take_in && !i_start_req && (r_st == S_DRAW);

    // start a division when a row setup begins and again for the short edge
    assign n_kick = (take_in && i_start_req && (y2 != y0))
                 || (emit && (r_col >= r_end) && (r_row + 1'b1 < tot))
                 || ((r_st == S_DIVA) && dv_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_kick  <= 1'b0;
            o_valid <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_end   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sx[k] <= '0;
                r_sy[k] <= '0;
            end
        end else begin
            r_kick <= n_kick;
            if (emit) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE, S_DRAW: begin
                    if (take_in && i_start_req) begin
                        r_sx[0] <= x0; r_sx[1] <= x1; r_sx[2] <= x2;
                        r_sy[0] <= y0; r_sy[1] <= y1; r_sy[2] <= y2;
                        r_row <= '0;
                        if (y2 == y0) begin
                            r_st  <= S_IDLE;
                            r_col <= '0;
                            r_end <= '0;
                        end else begin
                            r_st   <= S_DIVA;
                        end
                    end else if (emit) begin
                        o_pixel_x     <= r_col;
                        o_pixel_y     <= r_sy[0] + r_row;
                        o_pixel_color <= r_color;
                        o_last_pixel  <= is_last;
                        if (r_col < r_end) begin
                            r_col <= r_col + 1'b1;
                        end else begin
                            r_row <= r_row + 1'b1;
                            if (r_row + 1'b1 >= tot) begin
                                r_st <= S_IDLE;
                            end else begin
                                r_st   <= S_DIVA;
                            end
                        end
                    end
                end
                S_DIVA: begin
                    if (dv_done) begin
                        r_a    <= $signed({2'b00, r_sx[0]}) + $signed(quo[CB+1:0]);
                        r_st   <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (dv_done) begin
                        r_col <= lo[CB-1:0];
                        r_end <= hi[CB-1:0];
                        r_st  <= S_DRAW;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
